[sv/rbw_pkg.sv]
// Package for the RBSP bit writer: item function codes, sequencer states,
// and the emulation prevention byte. No dependencies.

package rbw_pkg;

  localparam int unsigned CodeW = 32;
  localparam int unsigned RemW  = 6;
  localparam int unsigned NbW   = 6;

  localparam logic [7:0] EscByte = 8'h03;

  typedef enum logic [1:0] {
    FUNC_FIXED = 2'd0,
    FUNC_UE    = 2'd1,
    FUNC_TRAIL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SHIFT,
    S_ESC,
    S_EMIT
  } state_e;

endpackage

[sv/rbsp_bit_writer_with_escape.sv]
// RBSP bit writer: fixed fields, ue(v) Exp-Golomb codes and trailing bits, packed MSB first
// into bytes with optional emulation prevention. Depends on rbw_pkg.
// After the accept edge, a ue(v) item first scans for leading zeros (nb = bit length of value + 1);
// then each code bit is packed, each byte goes out as its own output beat (escapes too), and a
// step returns to idle unless the last bit closes a byte; the longest ue(v) code has 63 bits.
// Throughput: one item at a time, ready only in idle. Reset: async, active low; clears the
// packer, zero run and output valid, sets escape_enable to 1.

module rbsp_bit_writer_with_escape (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_escape_enable_i,
  // input item channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [31:0]         value_i,
  input  logic [5:0]          bit_count_i,
  // output byte channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  import rbw_pkg::*;

  state_e            state_q, state_d;
  logic              esc_en_q;
  logic [6:0]        pb_q, pb_d;          // collected bits, shifted in at LSB
  logic [2:0]        filled_q, filled_d;
  logic [1:0]        zero_run_q, zero_run_d;
  logic [CodeW-1:0]  code_q, code_d;      // code right-aligned; only its low rem bits are packed
  logic [RemW-1:0]   rem_q, rem_d;        // code bits still to pack
  logic [CodeW-1:0]  scan_q, scan_d;      // leading-zero scan for ue(v)
  logic [NbW-1:0]    nb_q, nb_d;
  logic [7:0]        hold_q, hold_d;      // completed byte waiting to go out
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              last_q, last_d;

  logic              slot_free;
  logic              cur_bit;
  logic [7:0]        full_byte;
  logic [CodeW-1:0]  ue_val;
  logic [CodeW-1:0]  ue_code;
  logic [6:0]        ue_len;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // Output register is free when empty or draining this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  // Bits above the code width read as zero: leading zeros of wide fixed
  // fields and of ue(v) prefixes come out of here.
  assign cur_bit   = (rem_q <= RemW'(CodeW)) ? code_q[5'(rem_q - RemW'(1))] : 1'b0;
  assign full_byte = {pb_q, cur_bit};

  // Largest ue value saturates so that value + 1 fits in 32 bits.
  assign ue_val  = (value_i == '1) ? {{(CodeW-1){1'b1}}, 1'b0} : value_i;
  assign ue_code = ue_val + CodeW'(1);
  assign ue_len  = {nb_q, 1'b0} - 7'd1;

  always_comb begin
    state_d     = state_q;
    pb_d        = pb_q;
    filled_d    = filled_q;
    zero_run_d  = zero_run_q;
    code_d      = code_q;
    rem_d       = rem_q;
    scan_d      = scan_q;
    nb_d        = nb_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FUNC_FIXED: begin
              code_d  = value_i;
              rem_d   = bit_count_i;
              state_d = S_SHIFT;
            end
            FUNC_UE: begin
              code_d  = ue_code;
              scan_d  = ue_code;
              nb_d    = NbW'(CodeW);
              state_d = S_NORM;
            end
            FUNC_TRAIL: begin
              // a one bit, then zeros to the byte boundary
              code_d  = {{(CodeW-8){1'b0}}, 8'h80 >> filled_q};
              rem_d   = RemW'(8) - {3'b000, filled_q};
              state_d = S_SHIFT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_NORM: begin
        // code >= 1, so the scan always stops
        if (scan_q[CodeW-1]) begin
          rem_d   = ue_len[RemW-1:0];
          state_d = S_SHIFT;
        end else begin
          scan_d = {scan_q[CodeW-2:0], 1'b0};
          nb_d   = nb_q - NbW'(1);
        end
      end

      S_SHIFT: begin
        if (rem_q == '0) begin
          state_d = S_IDLE;
        end else begin
          rem_d = rem_q - RemW'(1);
          if (filled_q == 3'd7) begin
            hold_d   = full_byte;
            pb_d     = '0;
            filled_d = '0;
            if (esc_en_q && zero_run_q == 2'd2 && full_byte <= EscByte) begin
              state_d = S_ESC;
            end else begin
              state_d = S_EMIT;
            end
          end else begin
            pb_d     = {pb_q[5:0], cur_bit};
            filled_d = filled_q + 3'd1;
          end
        end
      end

      S_ESC: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = EscByte;
          last_d      = 1'b0;
          zero_run_d  = '0;
          state_d     = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = hold_q;
          // pack empty after a flush: another byte only if 8+ bits remain
          last_d      = (rem_q < RemW'(8));
          if (hold_q == 8'h00) begin
            zero_run_d = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
          end else begin
            zero_run_d = '0;
          end
          state_d = (rem_q == '0) ? S_IDLE : S_SHIFT;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      esc_en_q    <= 1'b1;
      pb_q        <= '0;
      filled_q    <= '0;
      zero_run_q  <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pb_q        <= pb_d;
      filled_q    <= filled_d;
      zero_run_q  <= zero_run_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        esc_en_q <= cfg_escape_enable_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    scan_q     <= scan_d;
    nb_q       <= nb_d;
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

`ifndef ASSERT_OFF
  // zero run saturates at two
  a_zero_run_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q != 2'd3)
    else $error("zero run counter overflowed");

  // idle means every code bit has been packed
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> rem_q == '0)
    else $error("idle with code bits left");

  // an escape is only pending for a small byte after two zero bytes
  a_esc_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ESC |-> hold_q <= EscByte && zero_run_q == 2'd2 && esc_en_q)
    else $error("escape pending without cause");

  // the escape beat is never the last beat of an item
  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ESC && slot_free |=> out_valid_q && !last_q && out_byte_q == EscByte)
    else $error("escape beat flagged last");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking bench for rbsp_bit_writer_with_escape: random and directed
// items, bytes predicted in-bench and checked in order.
// Depends on rbw_pkg and the writer RTL.

module tb;
  import rbw_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int CycleLimit = 400000;
  // The pause before a register write or the final verdict lets items that
  // emit nothing finish packing before the next step.
  localparam int SettleCycles = 120;
  localparam int PhaseItems = 68;

  typedef struct {
    func_e       func;
    logic [31:0] value;
    logic [5:0]  count;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // DUT-facing signals; the bench-driven ones are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  func_d = FUNC_FIXED;
  logic [31:0] value_d = '0;
  logic [5:0]  count_d = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_o;

  // bench bookkeeping
  item_t     pending_items[$];
  out_beat_t exp_bytes[$];
  int        items_left = 0;
  int        err_count = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 35;
  int        recv_idle_pct = 66;

  // predictor state: the bit packer as it should be after each beat
  logic [7:0] acc_byte = '0;
  int         acc_fill = 0;
  int         zero_cnt = 0;
  logic       esc_on = 1'b1;

  rbsp_bit_writer_with_escape dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_escape_enable_i (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .func_i              (func_d),
    .value_i             (value_d),
    .bit_count_i         (count_d),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .out_byte_o          (out_byte_o),
    .last_o              (last_o)
  );

  always #HalfPeriod clk = ~clk;

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------

  // One emitted byte; zero_cnt follows what actually goes out, the
  // escape byte included (it is nonzero, so it clears the run).
  task automatic emit_expected(input logic [7:0] b);
    exp_bytes.push_back('{data: b, last: 1'b0});
    if (b == 8'h00) begin
      if (zero_cnt < 2) zero_cnt++;
    end else begin
      zero_cnt = 0;
    end
  endtask

  task automatic flush_acc_byte();
    if (esc_on && zero_cnt >= 2 && acc_byte <= EscByte) emit_expected(EscByte);
    emit_expected(acc_byte);
    acc_byte = '0;
    acc_fill = 0;
  endtask

  // MSB-first, one bit at a time, exactly like the hardware packer
  task automatic pack_bits(input logic [63:0] code, input int len);
    for (int i = len; i > 0; i--) begin
      acc_byte[7 - acc_fill] = code[i - 1];
      acc_fill++;
      if (acc_fill == 8) flush_acc_byte();
    end
  endtask

  // Expected bytes for one accepted beat; tags the final one with last.
  task automatic encode_item(input item_t it);
    int          prev_size;
    int          nb;
    logic [63:0] code;
    prev_size = exp_bytes.size();
    case (it.func)
      FUNC_FIXED: begin
        // counts above 32 put zeros ahead of the value
        code = {32'd0, it.value};
        if (it.count < 32) code = code & ((64'd1 << it.count) - 64'd1);
        pack_bits(code, int'(it.count));
      end
      FUNC_UE: begin
        // all-ones saturates one below so code fits in 32 bits
        code = (it.value == 32'hFFFF_FFFF) ? 64'hFFFF_FFFE : {32'd0, it.value};
        code = code + 64'd1;
        nb = 0;
        while (nb < 33 && (code >> nb) != 64'd0) nb++;
        pack_bits(code, 2 * nb - 1);
      end
      FUNC_TRAIL: begin
        pack_bits(64'd1, 1);
        while (acc_fill != 0) pack_bits(64'd0, 1);
      end
      default: ;  // unused selector: nothing written
    endcase
    if (exp_bytes.size() > prev_size) exp_bytes[exp_bytes.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------
  // Driver: one beat in flight, valid held until taken
  // ---------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    item_t cur_item;
    item_t next_item;
    logic  fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready_o;
      if (fire) begin
        encode_item(cur_item);
        items_left--;
      end
      // only pick a new beat when nothing is being offered
      if (!in_valid || fire) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          cur_item  = next_item;
          func_d    <= next_item.func;
          value_d   <= next_item.value;
          count_d   <= next_item.count;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: in-order compare against the oldest expectation
  // ---------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h (cycle %0d)", what, got, want, cycle_cnt);
    err_count++;
  endtask

  always @(posedge clk) begin : check_bytes
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (exp_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_byte_o, 8'h00);
        end else begin
          want = exp_bytes.pop_front();
          if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
          if (last_o !== want.last) report_mismatch("last", {7'd0, last_o}, {7'd0, want.last});
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic add_item(input func_e f, input logic [31:0] v, input logic [5:0] c);
    pending_items.push_back('{func: f, value: v, count: c});
    items_left++;
  endtask

  // Weighted so zero bytes are common: that is what reaches the escape
  // path. Fields that an item ignores are still randomized.
  function automatic item_t rand_item();
    item_t it;
    int    r;
    int    k;
    it.func  = FUNC_FIXED;
    it.value = $urandom;
    it.count = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = $urandom_range(0, 9);
      if (k < 4)       it.count = 6'd8;
      else if (k < 7)  it.count = 6'($urandom_range(1, 32));
      else if (k == 7) it.count = ($urandom_range(0, 1) != 0) ? 6'd16 : 6'd24;
      else if (k == 8) it.count = 6'($urandom_range(33, 63));
      else             it.count = 6'd0;
      k = $urandom_range(0, 9);
      if (k < 4)       it.value = 32'd0;
      else if (k < 6)  it.value = 32'($urandom_range(0, 3));
      else if (k == 9) it.value = 32'hFFFF_FFFF;
    end else if (r < 80) begin
      it.func = FUNC_UE;
      k = $urandom_range(0, 9);
      if (k < 4)       it.value = 32'($urandom_range(0, 15));
      else if (k < 8)  it.value = $urandom >> $urandom_range(0, 31);
      else if (k == 8) it.value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
      else             it.value = 32'd0;
    end else if (r < 92) begin
      it.func = FUNC_TRAIL;
    end else if (r < 96) begin
      it.func = FUNC_NONE;
    end
    return it;
  endfunction

  // Register write; only called with the block idle.
  task automatic write_escape(input logic en);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    esc_on = en;
  endtask

  // All beats taken and all bytes seen, then a pause for silent items.
  task automatic drain_and_settle();
    while (items_left != 0 || exp_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic en);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_escape(en);
    for (int i = 0; i < PhaseItems; i++) pending_items.push_back(rand_item());
    items_left += PhaseItems;
    drain_and_settle();
  endtask

  // ---------------------------------------------------------------
  // Cycle counter / watchdog
  // ---------------------------------------------------------------
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, escape on from reset
    add_item(FUNC_FIXED, 32'hFFFF_FFFF, 6'd0);   // zero count: nothing out
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd8);
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd8);
    add_item(FUNC_FIXED, 32'h0000_0001, 6'd8);   // 00 00 then 01: escaped
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd16);
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd8);   // third zero also escaped
    add_item(FUNC_FIXED, 32'h0000_0003, 6'd8);   // escape byte clears run
    add_item(FUNC_FIXED, 32'h0000_0002, 6'd24);
    add_item(FUNC_FIXED, 32'hFFFF_FFFF, 6'd32);
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd32);  // escape mid-item
    add_item(FUNC_FIXED, 32'h0000_0004, 6'd8);   // 04 after zeros: no escape
    add_item(FUNC_FIXED, 32'hFFFF_FFFF, 6'd40);  // leading zeros ahead of value
    add_item(FUNC_FIXED, 32'h0000_0000, 6'd63);
    add_item(FUNC_TRAIL, 32'h0000_0000, 6'd0);
    add_item(FUNC_UE,    32'h0000_0000, 6'd63);
    add_item(FUNC_UE,    32'h0000_0001, 6'd0);
    add_item(FUNC_UE,    32'hFFFF_FFFF, 6'd0);   // saturates to the 63-bit code
    add_item(FUNC_UE,    32'hFFFF_FFFE, 6'd0);
    add_item(FUNC_UE,    32'h8000_0000, 6'd0);
    add_item(FUNC_NONE,  32'hFFFF_FFFF, 6'd63);  // unused selector
    add_item(FUNC_FIXED, 32'hFFFF_FFFE, 6'd1);
    add_item(FUNC_FIXED, 32'h0000_007F, 6'd7);
    add_item(FUNC_TRAIL, 32'hFFFF_FFFF, 6'd63);
    add_item(FUNC_TRAIL, 32'h0000_0000, 6'd0);   // already aligned: 0x80
    add_item(FUNC_UE,    32'h0000_000F, 6'd0);
    drain_and_settle();

    // Random phases; partial byte and zero run carry across the writes
    run_phase(35, 66, 1'b0);
    run_phase(35, 66, 1'b1);
    run_phase(66, 35, 1'b0);
    run_phase(66, 35, 1'b1);
    run_phase(0, 0, 1'b0);
    run_phase(0, 0, 1'b1);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
